>>> rtl/core/sobel_edge_magnitude_defines.svh
// Assertion macros for the Sobel edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SEM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sem_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

   localparam int LINE_DEPTH  = 1024;
   localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
   localparam int PIX_W       = 8;
   localparam int SIZE_W      = 11;
   localparam int MAG_W       = 11;
   localparam int CSR_INDEX_W = 8;

   localparam logic [SIZE_W-1:0] MAX_WIDTH   = SIZE_W'(LINE_DEPTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT  = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] RST_WIDTH   = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] RST_HEIGHT  = SIZE_W'(480);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   // 3x3 neighborhood; the center pixel does not enter either gradient.
   typedef struct packed {
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tc;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] ml;
      logic [PIX_W-1:0] mr;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] bc;
      logic [PIX_W-1:0] br;
   } win_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] res;
      if (value < MIN_SIZE) begin
         res = MIN_SIZE;
      end else if (value > maxv) begin
         res = maxv;
      end else begin
         res = value;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sobel_edge_magnitude.sv
// Streaming 3x3 Sobel edge magnitude, top level.
// Usage:
//   req_*  : one grayscale pixel per request, raster order from the top left.
//   rsp_*  : one response per interior pixel: |Gx|+|Gy|, its column and row,
//            and frame_last on the last interior pixel of the frame.
//   csr_*  : index 0 image_width, index 1 image_height; always ready. A write to
//            either restarts the frame (counters and window cleared, lines kept).
//            Sizes are clamped to 3..1024. Write only while the block is idle.
// Pipeline: an accepted pixel is registered in the read stage with its line
//   store read, then its result is registered in the output register; a stall
//   can hold it in either stage.
// Throughput: one pixel per cycle while the output is not stalled, set by the
//   single line store read and write per pixel; border pixels produce no response.
// Stall: while rsp_ready is low the output register holds, one more pixel
//   can sit in the read stage, and then req_ready drops.
// Reset: sizes return to 640 x 480, counters and window clear; the line
//   store is not cleared and the first two rows of a frame fill it.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_edge_magnitude_defines.svh"

module sobel_edge_magnitude (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [sem_pkg::PIX_W-1:0]          req_pixel,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [sem_pkg::MAG_W-1:0]          rsp_magnitude,
   output logic      [9:0]                         rsp_out_col,
   output logic      [9:0]                         rsp_out_row,
   output logic                                    rsp_frame_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sem_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sem_pkg::SIZE_W-1:0]         csr_data
);

   localparam int AW = sem_pkg::LINE_ADDR_W;
   localparam int PW = sem_pkg::PIX_W;
   localparam int SW = sem_pkg::SIZE_W;

   // Configuration
   logic [SW-1:0] width_ff, width_in, height_ff, height_in;
   logic          csr_fire, restart;

   // Position counters
   logic [AW-1:0] col_ff, col_in, row_ff, row_in;
   logic          col_end, row_end;

   // Read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pixel_ff;
   logic [AW-1:0] s1_col_ff, s1_row_ff;
   logic          s1_produce_ff, s1_last_ff;
   logic          s1_advance;

   // Window columns c-2 and c-1: top, mid, bottom
   logic [PW-1:0] win_ff [6];
   logic [PW-1:0] top, mid;

   logic [2*PW-1:0] rd_data;
   sem_pkg::win_type win;
   logic [sem_pkg::MAG_W-1:0] magnitude;

   // Output register
   logic          s2_valid_ff, s2_valid_in;
   logic [sem_pkg::MAG_W-1:0] s2_mag_ff;
   logic [AW-1:0] s2_col_ff, s2_row_ff;
   logic          s2_last_ff;

   logic req_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            sem_pkg::REG_IMAGE_WIDTH: begin
               width_in = sem_pkg::clamp_size(csr_data, sem_pkg::MAX_WIDTH);
               restart  = 1'b1;
            end
            sem_pkg::REG_IMAGE_HEIGHT: begin
               height_in = sem_pkg::clamp_size(csr_data, sem_pkg::MAX_HEIGHT);
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_advance = s1_valid_ff & (~s2_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign req_fire   = req_valid & req_ready;

   assign col_end = (SW'(col_ff) + SW'(1)) >= width_ff;
   assign row_end = (SW'(row_ff) + SW'(1)) >= height_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + AW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_valid_in = s1_produce_ff;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   sem_line_store u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_pixel_ff})
   );

   assign top = rd_data[2*PW-1:PW];
   assign mid = rd_data[PW-1:0];

   always_comb begin
      win.tl = win_ff[0];
      win.ml = win_ff[1];
      win.bl = win_ff[2];
      win.tc = win_ff[3];
      win.bc = win_ff[5];
      win.tr = top;
      win.mr = mid;
      win.br = s1_pixel_ff;
   end

   sem_gradient u_gradient (
      .win       (win),
      .magnitude (magnitude)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= sem_pkg::RST_WIDTH;
         height_ff   <= sem_pkg::RST_HEIGHT;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (restart) begin
            for (int i = 0; i < 6; i++) begin
               win_ff[i] <= '0;
            end
         end else if (s1_advance) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= s1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff   <= req_pixel;
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_produce_ff <= (col_ff >= AW'(2)) & (row_ff >= AW'(2));
         s1_last_ff    <= col_end & row_end;
      end
      if (s1_advance) begin
         s2_mag_ff  <= magnitude;
         s2_col_ff  <= s1_col_ff - AW'(1);
         s2_row_ff  <= s1_row_ff - AW'(1);
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_magnitude  = s2_mag_ff;
   assign rsp_out_col    = s2_col_ff;
   assign rsp_out_row    = s2_row_ff;
   assign rsp_frame_last = s2_last_ff;

   `SEM_ASSERT_IMPLY(a_col_in_line, clock, reset, 1'b1, SW'(col_ff) < width_ff, "column past line end")
   `SEM_ASSERT_IMPLY(a_rsp_interior, clock, reset, rsp_valid, (rsp_out_col != '0) && (rsp_out_row != '0) && (SW'(rsp_out_col) + SW'(2) <= width_ff), "border pixel in response")
   `SEM_ASSERT_IMPLY(a_last_corner, clock, reset, rsp_valid && rsp_frame_last, (SW'(rsp_out_col) + SW'(2) == width_ff) && (SW'(rsp_out_row) + SW'(2) == height_ff), "frame_last off corner")
   `SEM_ASSERT_IMPLY(a_full_backpressure, clock, reset, s1_valid_ff && rsp_valid && !rsp_ready, !req_ready, "request taken with pipeline full")

endmodule

`default_nettype wire

>>> rtl/core/sem_line_store.sv
// Two-line store: one 16-bit word per column holds {line_prev2, line_prev}.
`timescale 1ns / 1ps
`default_nettype none

module sem_line_store (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [sem_pkg::LINE_ADDR_W-1:0] rd_addr,
   output logic      [2*sem_pkg::PIX_W-1:0]   rd_data,
   input  wire logic                          wr_en,
   input  wire logic [sem_pkg::LINE_ADDR_W-1:0] wr_addr,
   input  wire logic [2*sem_pkg::PIX_W-1:0]   wr_data
);

   logic [2*sem_pkg::PIX_W-1:0] mem [sem_pkg::LINE_DEPTH];
   logic [2*sem_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/sem_gradient.sv
// Sobel horizontal and vertical gradients combined as |Gx| + |Gy|.
`timescale 1ns / 1ps
`default_nettype none

module sem_gradient (
   input  wire sem_pkg::win_type          win,
   output logic [sem_pkg::MAG_W-1:0]      magnitude
);

   localparam int SUM_W = sem_pkg::PIX_W + 2;

   logic [SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;

   always_comb begin
      gx_pos = SUM_W'(win.tr) + {1'b0, win.mr, 1'b0} + SUM_W'(win.br);
      gx_neg = SUM_W'(win.tl) + {1'b0, win.ml, 1'b0} + SUM_W'(win.bl);
      gy_pos = SUM_W'(win.tl) + {1'b0, win.tc, 1'b0} + SUM_W'(win.tr);
      gy_neg = SUM_W'(win.bl) + {1'b0, win.bc, 1'b0} + SUM_W'(win.br);
      gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      magnitude = sem_pkg::MAG_W'(gx_abs) + sem_pkg::MAG_W'(gy_abs);
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_sobel_edge_magnitude.sv
// Self-checking testbench for the streaming Sobel edge magnitude block.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BUDGET  = 90;

   localparam logic [sem_pkg::CSR_INDEX_W-1:0] UNMAPPED_REG = sem_pkg::CSR_INDEX_W'(254);

   typedef struct packed {
      logic [sem_pkg::MAG_W-1:0] magnitude;
      logic [9:0]                col;
      logic [9:0]                row;
      logic                      last;
   } edge_result_type;

   typedef struct {
      bit                              is_reg;
      logic [sem_pkg::CSR_INDEX_W-1:0] idx;
      logic [sem_pkg::SIZE_W-1:0]      data;
      logic [sem_pkg::PIX_W-1:0]       pixel;
      bit                              typed;
      edge_result_type                 want;
   } directed_step_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [sem_pkg::PIX_W-1:0]         req_pixel = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [sem_pkg::MAG_W-1:0]         rsp_magnitude;
   logic [9:0]                        rsp_out_col;
   logic [9:0]                        rsp_out_row;
   logic                              rsp_frame_last;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sem_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [sem_pkg::SIZE_W-1:0]        csr_data = '0;

   // typed expectation travels with the request it belongs to
   bit                                typed_valid = 1'b0;
   edge_result_type                   typed_result = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int hold_left     = 0;

   // predictor state
   logic [sem_pkg::SIZE_W-1:0] img_width  = sem_pkg::RST_WIDTH;
   logic [sem_pkg::SIZE_W-1:0] img_height = sem_pkg::RST_HEIGHT;
   bit [7:0]     stored_prev  [sem_pkg::LINE_DEPTH];
   bit [7:0]     stored_prev2 [sem_pkg::LINE_DEPTH];
   bit [7:0]     win [6];
   int           col_pos = 0;
   int           row_pos = 0;
   edge_result_type expected_edges [$];

   directed_step_type directed_steps [$];

   int pixels_taken  = 0;
   int edges_checked = 0;
   int regs_written  = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;

   sobel_edge_magnitude dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int effective_size(input logic [sem_pkg::SIZE_W-1:0] v,
                                         input logic [sem_pkg::SIZE_W-1:0] maxv);
      if (v < sem_pkg::MIN_SIZE) begin
         return sem_pkg::MIN_SIZE;
      end
      if (v > maxv) begin
         return maxv;
      end
      return v;
   endfunction

   function automatic void apply_register(input logic [sem_pkg::CSR_INDEX_W-1:0] idx,
                                          input logic [sem_pkg::SIZE_W-1:0] val);
      regs_written++;
      if (idx == sem_pkg::REG_IMAGE_WIDTH || idx == sem_pkg::REG_IMAGE_HEIGHT) begin
         if (idx == sem_pkg::REG_IMAGE_WIDTH) begin
            img_width = val;
         end else begin
            img_height = val;
         end
         foreach (win[i]) win[i] = 8'h00;
         col_pos = 0;
         row_pos = 0;
      end
   endfunction

   function automatic void advance_window(input logic [7:0] pix, input bit typed,
                                          input edge_result_type want);
      int w, h, c, r, tl, ml, bl, tc, bc, tr, mr, br, gx, gy;
      edge_result_type res;
      w = effective_size(img_width, sem_pkg::MAX_WIDTH);
      h = effective_size(img_height, sem_pkg::MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      tr = stored_prev2[c];
      mr = stored_prev[c];
      br = pix;
      stored_prev2[c] = 8'(mr);
      stored_prev[c]  = pix;
      if (r >= 2 && c >= 2) begin
         tl = win[0];
         ml = win[1];
         bl = win[2];
         tc = win[3];
         bc = win[5];
         gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
         gy = (tl + 2 * tc + tr) - (bl + 2 * bc + br);
         if (gx < 0) gx = -gx;
         if (gy < 0) gy = -gy;
         res.magnitude = sem_pkg::MAG_W'(gx + gy);
         res.col       = 10'(c - 1);
         res.row       = 10'(r - 1);
         res.last      = (c + 1 == w) && (r + 1 == h);
         expected_edges.push_back(typed ? want : res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = 8'(tr);
      win[4] = 8'(mr);
      win[5] = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // monitor: prediction, checking and watchdog in one process
   always @(posedge clock) begin
      edge_result_type got, want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            advance_window(req_pixel, typed_valid, typed_result);
            pixels_taken++;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_magnitude, rsp_out_col, rsp_out_row, rsp_frame_last};
            moved = 1'b1;
            if (expected_edges.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result mag %0d col %0d row %0d last %0d",
                        $time, got.magnitude, got.col, got.row, got.last);
            end else begin
               want = expected_edges.pop_front();
               edges_checked++;
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: mismatch expected mag %0d col %0d row %0d last %0d, got mag %0d col %0d row %0d last %0d",
                           $time, want.magnitude, want.col, want.row, want.last,
                           got.magnitude, got.col, got.row, got.last);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_edges.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // response side: random stalls plus requested long holds
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_pixel(input logic [7:0] pix, input bit typed = 1'b0,
                             input edge_result_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel    <= pix;
      typed_valid  <= typed;
      typed_result <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [7:0] pix;
      repeat (count) begin
         case ($urandom_range(7))
            0: pix = 8'h00;
            1: pix = 8'hFF;
            default: pix = 8'($urandom);
         endcase
         send_pixel(pix);
      end
   endtask

   // stop sending and wait until the block has nothing left in flight
   task automatic settle();
      req_valid <= 1'b0;
      do begin
         while (expected_edges.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (expected_edges.size() != 0);
   endtask

   task automatic write_reg(input logic [sem_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sem_pkg::SIZE_W-1:0] val, input bit drop_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (drop_valid) csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [sem_pkg::SIZE_W-1:0] w,
                           input logic [sem_pkg::SIZE_W-1:0] h);
      write_reg(sem_pkg::REG_IMAGE_WIDTH, w, 1'b0);
      write_reg(sem_pkg::REG_IMAGE_HEIGHT, h, 1'b1);
   endtask

   function automatic logic [sem_pkg::SIZE_W-1:0] pick_size(input int common_hi,
                                                            input int rare_hi);
      case ($urandom_range(9))
         0: return sem_pkg::SIZE_W'($urandom_range(2));
         1: return sem_pkg::SIZE_W'($urandom_range(rare_hi, common_hi + 1));
         default: return sem_pkg::SIZE_W'($urandom_range(common_hi, 3));
      endcase
   endfunction

   task automatic random_phase(input int idle_pct, input int stall, input int budget);
      int done, frame_len, part;
      logic [sem_pkg::SIZE_W-1:0] w_val, h_val;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      done          = 0;
      while (done < budget) begin
         settle();
         w_val = pick_size(8, 24);
         h_val = pick_size(6, 10);
         set_size(w_val, h_val);
         frame_len = effective_size(w_val, sem_pkg::MAX_WIDTH)
                     * effective_size(h_val, sem_pkg::MAX_HEIGHT);
         if ($urandom_range(9) < 3) begin
            // cut-off frame; sometimes an unmapped write lands inside it
            part = $urandom_range(frame_len - 1, 1);
            send_random(part);
            done += part;
            if ($urandom_range(1) == 1) begin
               settle();
               write_reg(sem_pkg::CSR_INDEX_W'($urandom_range(255, 2)),
                         sem_pkg::SIZE_W'($urandom), 1'b1);
               send_random(frame_len - part);
               done += frame_len - part;
            end
         end else begin
            part = frame_len * $urandom_range(2, 1);
            send_random(part);
            done += part;
         end
      end
   endtask

   function automatic void tab_reg(input logic [sem_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [sem_pkg::SIZE_W-1:0] data);
      directed_step_type s;
      s = '{is_reg: 1'b1, idx: idx, data: data, pixel: '0, typed: 1'b0, want: '0};
      directed_steps.push_back(s);
   endfunction

   function automatic void tab_pix(input logic [7:0] p);
      directed_step_type s;
      s = '{is_reg: 1'b0, idx: '0, data: '0, pixel: p, typed: 1'b0, want: '0};
      directed_steps.push_back(s);
   endfunction

   function automatic void tab_want(input logic [7:0] p, input int mag, input int col,
                                    input int row, input bit last);
      directed_step_type s;
      s = '{is_reg: 1'b0, idx: '0, data: '0, pixel: p, typed: 1'b1,
            want: '{sem_pkg::MAG_W'(mag), 10'(col), 10'(row), last}};
      directed_steps.push_back(s);
   endfunction

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: the start of a 640-pixel line gives no response
      send_idle_pct = 20;
      stall_pct     = 20;
      send_random(40);

      // sizes below the minimum, a top edge, a corner, an ignored write mid-frame
      tab_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::SIZE_W'(2));
      tab_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::SIZE_W'(0));
      tab_pix(8'hFF); tab_pix(8'hFF); tab_pix(8'hFF);
      tab_pix(8'h00); tab_pix(8'h00); tab_pix(8'h00);
      tab_pix(8'h00); tab_pix(8'h00); tab_want(8'h00, 1020, 1, 1, 1'b1);
      tab_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::SIZE_W'(5));
      tab_pix(8'h00); tab_pix(8'hFF); tab_pix(8'hFF);
      tab_pix(8'h00); tab_pix(8'h00); tab_pix(8'hFF);
      tab_pix(8'h00); tab_pix(8'h00); tab_want(8'h00, 1530, 1, 1, 1'b0);
      tab_reg(UNMAPPED_REG, sem_pkg::SIZE_W'(11'h5A5));
      tab_pix(8'hFF); tab_pix(8'hFF); tab_pix(8'hFF);
      tab_pix(8'hFF); tab_pix(8'hFF); tab_want(8'hFF, 1020, 1, 3, 1'b1);

      for (int i = 0; i < directed_steps.size(); i++) begin
         if (directed_steps[i].is_reg) begin
            if (i == 0 || !directed_steps[i-1].is_reg) settle();
            write_reg(directed_steps[i].idx, directed_steps[i].data,
                      i + 1 == directed_steps.size() || !directed_steps[i+1].is_reg);
         end else begin
            send_pixel(directed_steps[i].pixel, directed_steps[i].typed,
                       directed_steps[i].want);
         end
      end

      // size extremes, clamping from above and below, cut-off frames
      settle();
      set_size(sem_pkg::SIZE_W'(11'h7FF), sem_pkg::SIZE_W'(3));
      send_random(40);
      settle();
      set_size(sem_pkg::SIZE_W'(0), sem_pkg::SIZE_W'(11'h7FF));
      send_random(40);

      // long response hold while requests keep coming
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_size(sem_pkg::SIZE_W'(3), sem_pkg::SIZE_W'(4));
      holds_asked = holds_asked + 1;
      send_random(60);

      random_phase(0, 0, RANDOM_BUDGET);
      random_phase(45, 0, RANDOM_BUDGET);
      random_phase(0, 45, RANDOM_BUDGET);
      random_phase(33, 33, RANDOM_BUDGET);
      settle();

      $display("Checked %0d edge results from %0d pixels across %0d register writes",
               edges_checked, pixels_taken, regs_written);
      $display("Reset and clamped sizes, ignored writes, idle and stall mixes, long hold; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
